>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the blitter core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> design/sbk_pkg.sv
// ----------------------------------------------------------------------------
// sbk_pkg
// Types, sizes and helpers shared by the sprite blitter core.
// ----------------------------------------------------------------------------
`default_nettype none

package sbk_pkg;

	localparam int MAX_DIM = 2048;
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = CNT_W + 1;
	localparam int POS_W   = ((CNT_W > 11) ? CNT_W : 11) + 2;
	localparam int ADDR_W  = 22;
	localparam int PIX_W   = 8;
	localparam int CFG_W   = 12;
	localparam int IDX_W   = 3;
	localparam int Q_DEPTH = 2;
	localparam int QP_W    = $clog2(Q_DEPTH);

	typedef enum logic [IDX_W-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_SPRITE_WIDTH  = 3'd2,
		REG_SPRITE_HEIGHT = 3'd3,
		REG_FRAME_WIDTH   = 3'd4,
		REG_FRAME_HEIGHT  = 3'd5,
		REG_KEY_COLOR     = 3'd6,
		REG_FLIP_MODE     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [11:0] dest_x;
		logic signed [11:0] dest_y;
		logic [11:0]        sprite_width;
		logic [11:0]        sprite_height;
		logic [11:0]        frame_width;
		logic [11:0]        frame_height;
		logic [8:0]         key_color;
		logic [1:0]         flip_mode;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]        pixel;
		logic signed [POS_W-1:0] dcol;
		logic signed [POS_W-1:0] drow;
		logic                    done;
	} q_item_t;

	function automatic logic [DIM_W-1:0] sprite_dim(input logic [11:0] v);
		logic [DIM_W-1:0] r;
		if (v == 12'd0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] frame_dim(input logic [11:0] v);
		logic [DIM_W-1:0] r;
		if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/sbk_front.sv
// ----------------------------------------------------------------------------
// sbk_front
// Accepts source pixels, tracks column and row, resolves mirrored positions
// and the end-of-sprite flag, and pushes each word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbk_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sbk_pkg::cfg_t              cfg,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,   // src_pixel
	input  wire logic                       q_full,
	output logic                            push,
	output sbk_pkg::q_item_t                push_item
);

	logic [sbk_pkg::CNT_W-1:0] col_q;
	logic [sbk_pkg::CNT_W-1:0] row_q;
	logic [sbk_pkg::DIM_W-1:0] sw;
	logic [sbk_pkg::DIM_W-1:0] sh;
	logic [sbk_pkg::CNT_W-1:0] sw_m1;
	logic [sbk_pkg::CNT_W-1:0] sh_m1;
	logic                      last_col;
	logic                      last_row;

	assign sw    = sbk_pkg::sprite_dim(cfg.sprite_width);
	assign sh    = sbk_pkg::sprite_dim(cfg.sprite_height);
	assign sw_m1 = sbk_pkg::CNT_W'(sw - sbk_pkg::DIM_W'(1));
	assign sh_m1 = sbk_pkg::CNT_W'(sh - sbk_pkg::DIM_W'(1));

	assign last_col = (col_q >= sw_m1);
	assign last_row = (row_q >= sh_m1);

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_item.pixel = s_tdata;
		push_item.done  = last_col && last_row;
		if (cfg.flip_mode[0]) begin
			push_item.dcol = $signed(sbk_pkg::POS_W'(sw_m1)) - $signed(sbk_pkg::POS_W'(col_q));
		end else begin
			push_item.dcol = $signed(sbk_pkg::POS_W'(col_q));
		end
		if (cfg.flip_mode[1]) begin
			push_item.drow = $signed(sbk_pkg::POS_W'(sh_m1)) - $signed(sbk_pkg::POS_W'(row_q));
		end else begin
			push_item.drow = $signed(sbk_pkg::POS_W'(row_q));
		end
	end

	// advance counters, restart at end of sprite
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/sbk_queue.sv
// ----------------------------------------------------------------------------
// sbk_queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sbk_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sbk_pkg::q_item_t  push_item,
	output logic                   full,
	input  wire logic              pop,
	output logic                   q_valid,
	output sbk_pkg::q_item_t       q_item
);

	sbk_pkg::q_item_t          entries_q [sbk_pkg::Q_DEPTH];
	logic [sbk_pkg::QP_W-1:0]  wr_ptr_q;
	logic [sbk_pkg::QP_W-1:0]  rd_ptr_q;
	logic [sbk_pkg::QP_W:0]    count_q;

	assign full    = (count_q == (sbk_pkg::QP_W+1)'(sbk_pkg::Q_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPLY(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`ASSERT_IMPLY(a_no_push_full, clk, arst_n, push, !full)

endmodule

`default_nettype wire

>>> design/sbk_back.sv
// ----------------------------------------------------------------------------
// sbk_back
// Clips against the framebuffer, applies the colour key and forms the
// framebuffer address in a three-stage elastic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sbk_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sbk_pkg::cfg_t     cfg,
	input  wire logic              q_valid,
	input  wire sbk_pkg::q_item_t  q_item,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [31:0]            m_tdata,   // write_enable, fb_address, pixel_out, pad
	output logic                   m_tlast    // sprite_done
);

	localparam int PROD_W = sbk_pkg::CNT_W + sbk_pkg::DIM_W;

	logic [sbk_pkg::DIM_W-1:0]       fw;
	logic [sbk_pkg::DIM_W-1:0]       fh;
	logic signed [sbk_pkg::POS_W-1:0] fw_s;
	logic signed [sbk_pkg::POS_W-1:0] fh_s;
	logic signed [sbk_pkg::POS_W-1:0] dx;
	logic signed [sbk_pkg::POS_W-1:0] dy;
	logic                            in_frame;
	logic                            keyed;

	logic                            v_s1, v_s2, v_s3;
	logic                            rdy1, rdy2, rdy3;

	logic                            we_s1;
	logic [sbk_pkg::CNT_W-1:0]       dx_s1;
	logic [sbk_pkg::CNT_W-1:0]       dy_s1;
	logic [sbk_pkg::PIX_W-1:0]       pix_s1;
	logic                            done_s1;

	logic                            we_s2;
	logic [sbk_pkg::CNT_W-1:0]       dx_s2;
	logic [PROD_W-1:0]               prod_s2;
	logic [sbk_pkg::PIX_W-1:0]       pix_s2;
	logic                            done_s2;

	logic                            we_s3;
	logic [sbk_pkg::ADDR_W-1:0]      addr_s3;
	logic [sbk_pkg::PIX_W-1:0]       pix_s3;
	logic                            done_s3;

	assign fw   = sbk_pkg::frame_dim(cfg.frame_width);
	assign fh   = sbk_pkg::frame_dim(cfg.frame_height);
	assign fw_s = $signed(sbk_pkg::POS_W'(fw));
	assign fh_s = $signed(sbk_pkg::POS_W'(fh));

	assign dx = sbk_pkg::POS_W'(cfg.dest_x) + q_item.dcol;
	assign dy = sbk_pkg::POS_W'(cfg.dest_y) + q_item.drow;

	assign in_frame = (dx >= 0) && (dx < fw_s) && (dy >= 0) && (dy < fh_s);
	assign keyed    = !cfg.key_color[8] && (q_item.pixel == cfg.key_color[7:0]);

	assign rdy3 = !v_s3 || m_tready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pop  = q_valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= q_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			we_s1   <= in_frame && !keyed;
			dx_s1   <= sbk_pkg::CNT_W'(dx);
			dy_s1   <= sbk_pkg::CNT_W'(dy);
			pix_s1  <= q_item.pixel;
			done_s1 <= q_item.done;
		end
		if (rdy2) begin
			we_s2   <= we_s1;
			dx_s2   <= dx_s1;
			prod_s2 <= dy_s1 * fw;
			pix_s2  <= pix_s1;
			done_s2 <= done_s1;
		end
		if (rdy3) begin
			we_s3   <= we_s2;
			addr_s3 <= we_s2 ? sbk_pkg::ADDR_W'(prod_s2) + sbk_pkg::ADDR_W'(dx_s2) : '0;
			pix_s3  <= pix_s2;
			done_s3 <= done_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {1'b0, pix_s3, addr_s3, we_s3};
	assign m_tlast  = done_s3;

	`ASSERT_IMPLY(a_off_addr_zero, clk, arst_n, v_s3 && !we_s3, addr_s3 == '0)
	`ASSERT_NEXT(a_s2_holds, clk, arst_n, v_s2 && !rdy3, v_s2 && $stable(prod_s2))

endmodule

`default_nettype wire

>>> design/sprite_blit_clip_flip_key_core.sv
// Sprite blitter core: takes one 8-bit indexed source pixel per clock in source
// raster order and gives one framebuffer write word per pixel (enable, address,
// colour), with mirroring, clipping to the framebuffer and an optional colour
// key; tlast marks the final pixel of the sprite. Sustained rate is one pixel
// per clock in both directions while the output is not stalled. The pixel
// counters in the front part and the row-times-pitch multiply stage in the back
// part each handle one pixel per cycle unless stalled, and a two-word queue
// lets either side stall on its own. Write configuration registers only while
// no pixels are in flight.
// ----------------------------------------------------------------------------
// sprite_blit_clip_flip_key_core
// Top level: configuration registers, front, queue and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blit_clip_flip_key_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sbk_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [sbk_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,   // src_pixel
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [31:0]                      m_tdata,   // write_enable, fb_address, pixel_out, pad
	output logic                             m_tlast    // sprite_done
);

	sbk_pkg::cfg_t    cfg_q;
	logic             q_full;
	logic             push;
	sbk_pkg::q_item_t push_item;
	logic             pop;
	logic             q_valid;
	sbk_pkg::q_item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x        <= '0;
			cfg_q.dest_y        <= '0;
			cfg_q.sprite_width  <= 12'd1;
			cfg_q.sprite_height <= 12'd1;
			cfg_q.frame_width   <= 12'd1;
			cfg_q.frame_height  <= 12'd1;
			cfg_q.key_color     <= '1;
			cfg_q.flip_mode     <= '0;
		end else if (cfg_we) begin
			unique case (sbk_pkg::reg_idx_t'(cfg_index))
				sbk_pkg::REG_DEST_X:        cfg_q.dest_x        <= $signed(cfg_data);
				sbk_pkg::REG_DEST_Y:        cfg_q.dest_y        <= $signed(cfg_data);
				sbk_pkg::REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data;
				sbk_pkg::REG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data;
				sbk_pkg::REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data;
				sbk_pkg::REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data;
				sbk_pkg::REG_KEY_COLOR:     cfg_q.key_color     <= cfg_data[8:0];
				sbk_pkg::REG_FLIP_MODE:     cfg_q.flip_mode     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	sbk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	sbk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	sbk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
